@@ rtl/core/asd_pkg.sv @@
// shared types and constants for the archive stream deframer
package asd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [WORD_W-1:0] MAGIC_RST = 32'h504B_0304;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // parse phase and output field kind share the same codes
  typedef enum logic [KIND_W-1:0] {
    PH_MAGIC   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_NAMELEN = 3'd2,
    PH_NAME    = 3'd3,
    PH_SIZE    = 3'd4,
    PH_DATA    = 3'd5,
    PH_TRAIL   = 3'd6,
    PH_REJECT  = 3'd7
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAGIC   = 3'd0,
    KIND_COUNT   = 3'd1,
    KIND_NAMELEN = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_SIZE    = 3'd4,
    KIND_DATA    = 3'd5,
    KIND_TRAIL   = 3'd6,
    KIND_REJECT  = 3'd7
  } field_kind_e;

  typedef struct packed {
    field_kind_e       field_kind;
    logic [BYTE_W-1:0] byte_out;
    logic [WORD_W-1:0] file_num;
    logic              field_last;
    logic              all_files_done;
    logic              truncated;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } res_push_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] level;
  } fifo_stat_t;

endpackage

@@ rtl/core/asd_stream_if.sv @@
// stream interfaces for the deframer input and output channels
interface asd_in_if import asd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              archive_start;
  logic              archive_end;

  modport source (output valid, stream_byte, archive_start, archive_end, input ready);
  modport sink   (input valid, stream_byte, archive_start, archive_end, output ready);
endinterface

interface asd_out_if import asd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] field_kind;
  logic [BYTE_W-1:0] byte_out;
  logic [WORD_W-1:0] file_num;
  logic              field_last;
  logic              all_files_done;
  logic              truncated;

  modport source (output valid, field_kind, byte_out, file_num, field_last,
                  all_files_done, truncated, input ready);
  modport sink   (input valid, field_kind, byte_out, file_num, field_last,
                  all_files_done, truncated, output ready);
endinterface

@@ rtl/core/archive_stream_deframer_core.sv @@
// archive stream deframer top level: parser, result queue and output register
//
// usage:
// - in_i carries one archive byte per beat with archive_start / archive_end
//   marks; out_o returns exactly one tagged beat per input beat, in order
// - each output beat carries the field kind, the byte, the file index, a
//   field-last mark, an all-files-done flag and a truncated flag
// - magic_word_i is written on any edge with magic_word_we_i high; write it
//   only while no beats are in flight
// - throughput: one byte per cycle sustained while the queue has room; the parser
//   updates its phase and counters once for each accepted byte
// - path: the parser writes each accepted beat into the four-entry queue, and
//   the queue refills the output register whenever that register is empty or
//   being taken
// - receiver stall: the output register holds, the queue fills, and in_i
//   ready drops only once all four queue entries are occupied
// - reset: parse state returns to the magic phase, the magic register to
//   50 4B 03 04, queue and output register empty
module archive_stream_deframer_core import asd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              magic_word_we_i,
  input  logic [WORD_W-1:0] magic_word_i,
  asd_in_if.sink            in_i,
  asd_out_if.source         out_o
);

  res_push_t  push;
  res_t       rd_data;
  fifo_stat_t fifo_stat;
  logic       pop;

  // front: format walk and tagging, one beat per cycle while the queue has room
  asd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .magic_word_we_i(magic_word_we_i),
    .magic_word_i   (magic_word_i),
    .in_i           (in_i),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push)
  );

  // decoupling queue so either side can stall alone
  asd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .rd_data_o(rd_data),
    .stat_o   (fifo_stat)
  );

  // back: registered output toward the receiver
  asd_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_data_i  (rd_data),
    .fifo_stat_i(fifo_stat),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // queue level only moves on a push or a pop
  a_level_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push.valid && !pop) |=> $stable(fifo_stat.level))
    else $error("queue level changed without push or pop");

  // input backpressure only when the queue is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> fifo_stat.full)
    else $error("input stalled with room in queue");

  // output register empties when taken with nothing queued
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && fifo_stat.empty) |=> !out_o.valid)
    else $error("output stayed valid after drain");

  // rejected bytes never carry a file index or field end
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.valid && push.data.field_kind == KIND_REJECT)
      |-> (push.data.file_num == '0 && !push.data.field_last))
    else $error("rejected byte tagged with file or field end");

endmodule

@@ rtl/core/asd_parser.sv @@
// front end: accepts bytes, walks the archive format and tags each byte
module asd_parser import asd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              magic_word_we_i,
  input  logic [WORD_W-1:0] magic_word_i,
  asd_in_if.sink            in_i,
  input  fifo_stat_t        fifo_stat_i,
  output res_push_t         push_o
);

  logic [WORD_W-1:0] magic_q;
  phase_e            phase_q, phase_d;
  logic [1:0]        pos_q, pos_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] frem_q, frem_d;
  logic [WORD_W-1:0] brem_q, brem_d;
  logic [WORD_W-1:0] cur_q, cur_d;

  // state as seen by this beat, after an archive start
  phase_e            phase;
  logic [1:0]        pos;
  logic [WORD_W-1:0] acc, frem, brem, cur;
  logic [WORD_W-1:0] acc_sh, brem_dec;
  logic [BYTE_W-1:0] want, b;
  logic              accept;
  res_t              res;

  assign in_i.ready = !fifo_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.stream_byte & BYTE_MASK;

  always_comb begin
    if (in_i.archive_start) begin
      phase = PH_MAGIC;
      pos   = 2'd0;
      acc   = '0;
      frem  = '0;
      brem  = '0;
      cur   = '0;
    end else begin
      phase = phase_q;
      pos   = pos_q;
      acc   = acc_q;
      frem  = frem_q;
      brem  = brem_q;
      cur   = cur_q;
    end

    acc_sh   = {acc[WORD_W-BYTE_W-1:0], b};
    brem_dec = brem - WORD_W'(1);

    unique case (pos)
      2'd0:    want = magic_q[31:24];
      2'd1:    want = magic_q[23:16];
      2'd2:    want = magic_q[15:8];
      default: want = magic_q[7:0];
    endcase

    phase_d = phase;
    pos_d   = pos;
    acc_d   = acc;
    frem_d  = frem;
    brem_d  = brem;
    cur_d   = cur;

    res.byte_out   = b;
    res.file_num   = '0;
    res.field_last = 1'b0;
    res.field_kind = KIND_REJECT;

    unique case (phase)
      PH_MAGIC: begin
        if (b != want) begin
          res.field_kind = KIND_REJECT;
          phase_d        = PH_REJECT;
        end else begin
          res.field_kind = KIND_MAGIC;
          if (pos == 2'd3) begin
            res.field_last = 1'b1;
            pos_d          = 2'd0;
            acc_d          = '0;
            phase_d        = PH_COUNT;
          end else begin
            pos_d = pos + 2'd1;
          end
        end
      end
      PH_COUNT: begin
        res.field_kind = KIND_COUNT;
        acc_d          = acc_sh;
        if (pos == 2'd3) begin
          res.field_last = 1'b1;
          pos_d          = 2'd0;
          frem_d         = acc_sh;
          acc_d          = '0;
          phase_d        = (acc_sh == '0) ? PH_TRAIL : PH_NAMELEN;
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PH_NAMELEN: begin
        res.field_kind = KIND_NAMELEN;
        res.file_num   = cur;
        acc_d          = acc_sh;
        if (pos != 2'd0) begin
          res.field_last = 1'b1;
          pos_d          = 2'd0;
          brem_d         = {16'd0, acc_sh[15:0]};
          acc_d          = '0;
          phase_d        = (acc_sh[15:0] == 16'd0) ? PH_SIZE : PH_NAME;
        end else begin
          pos_d = 2'd1;
        end
      end
      PH_NAME: begin
        res.field_kind = KIND_NAME;
        res.file_num   = cur;
        brem_d         = brem_dec;
        if (brem_dec == '0) begin
          res.field_last = 1'b1;
          pos_d          = 2'd0;
          acc_d          = '0;
          phase_d        = PH_SIZE;
        end
      end
      PH_SIZE: begin
        res.field_kind = KIND_SIZE;
        res.file_num   = cur;
        acc_d          = acc_sh;
        if (pos == 2'd3) begin
          res.field_last = 1'b1;
          pos_d          = 2'd0;
          brem_d         = acc_sh;
          acc_d          = '0;
          if (acc_sh == '0) begin
            // empty data: the file ends here
            cur_d   = cur + WORD_W'(1);
            frem_d  = frem - WORD_W'(1);
            phase_d = (frem == WORD_W'(1)) ? PH_TRAIL : PH_NAMELEN;
          end else begin
            phase_d = PH_DATA;
          end
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PH_DATA: begin
        res.field_kind = KIND_DATA;
        res.file_num   = cur;
        brem_d         = brem_dec;
        if (brem_dec == '0) begin
          res.field_last = 1'b1;
          acc_d          = '0;
          cur_d          = cur + WORD_W'(1);
          frem_d         = frem - WORD_W'(1);
          phase_d        = (frem == WORD_W'(1)) ? PH_TRAIL : PH_NAMELEN;
        end
      end
      PH_TRAIL: begin
        res.field_kind = KIND_TRAIL;
        res.file_num   = cur;
      end
      PH_REJECT: begin
        res.field_kind = KIND_REJECT;
      end
    endcase

    res.all_files_done = (phase_d == PH_TRAIL);
    res.truncated      = in_i.archive_end && (phase_d != PH_TRAIL) && (phase_d != PH_REJECT);

    // end of archive returns the parse to its reset point
    if (in_i.archive_end) begin
      phase_d = PH_MAGIC;
      pos_d   = 2'd0;
      acc_d   = '0;
      frem_d  = '0;
      brem_d  = '0;
      cur_d   = '0;
    end
  end

  assign push_o.valid = accept;
  assign push_o.data  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MAGIC_RST;
      phase_q <= PH_MAGIC;
      pos_q   <= 2'd0;
      acc_q   <= '0;
      frem_q  <= '0;
      brem_q  <= '0;
      cur_q   <= '0;
    end else begin
      if (magic_word_we_i) begin
        magic_q <= magic_word_i;
      end
      if (accept) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        acc_q   <= acc_d;
        frem_q  <= frem_d;
        brem_q  <= brem_d;
        cur_q   <= cur_d;
      end
    end
  end

endmodule

@@ rtl/core/asd_fifo.sv @@
// small result queue between the parser and the output stage
module asd_fifo import asd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_push_t  push_i,
  input  logic       pop_i,
  output res_t       rd_data_o,
  output fifo_stat_t stat_o
);

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign do_push = push_i.valid && (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.level = cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/asd_emit.sv @@
// back end: output register that drains the queue toward the receiver
module asd_emit import asd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       rd_data_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       pop_o,
  asd_out_if.source  out_o
);

  logic out_valid_q, out_valid_d;
  res_t out_q;

  // refill from the queue, when it holds a beat, whenever the register is empty or being taken this cycle
  assign pop_o       = !fifo_stat_i.empty && (!out_valid_q || out_o.ready);
  assign out_valid_d = pop_o || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= rd_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.field_kind     = out_q.field_kind;
  assign out_o.byte_out       = out_q.byte_out;
  assign out_o.file_num       = out_q.file_num;
  assign out_o.field_last     = out_q.field_last;
  assign out_o.all_files_done = out_q.all_files_done;
  assign out_o.truncated      = out_q.truncated;

endmodule

@@ tb/sv/tb_archive_stream_deframer_core.sv @@
// self-checking testbench for the archive stream deframer core
`timescale 1ns / 1ps

module tb_archive_stream_deframer_core;
  import asd_pkg::*;

  // 8 runs over the four idling modes, about 1450 beats in all
  localparam int unsigned RUNS           = 8;
  localparam int unsigned BEATS_PER_RUN  = 182;
  // settling margin after the last expected beat is checked
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum int unsigned {
    MODE_FREE,
    MODE_SRC_GAPS,
    MODE_SNK_STALLS,
    MODE_BOTH
  } idle_mode_e;

  // one input beat; pinned beats carry an expected tag typed in by hand
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              pinned;
    res_t              pinned_tag;
  } beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              magic_we;
  logic [WORD_W-1:0] magic_wdata;

  asd_in_if  in_if ();
  asd_out_if out_if ();

  archive_stream_deframer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .magic_word_we_i (magic_we),
    .magic_word_i    (magic_wdata),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  always #5 clk_i = ~clk_i;

  // parser mirror: phase, header position, field accumulator and counters
  phase_e            prs_phase;
  logic [1:0]        hdr_pos;
  logic [WORD_W-1:0] acc_q;
  logic [WORD_W-1:0] files_left;
  logic [WORD_W-1:0] bytes_left;
  logic [WORD_W-1:0] file_idx;
  logic [WORD_W-1:0] magic_q;

  beat_t       beat_q[$];     // beats waiting to be sent
  res_t        tag_q[$];      // tags expected back, oldest first
  idle_mode_e  mode = MODE_FREE;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  function automatic void restart_parse();
    prs_phase  = PH_MAGIC;
    hdr_pos    = '0;
    acc_q      = '0;
    files_left = '0;
    bytes_left = '0;
    file_idx   = '0;
  endfunction

  // a file is done: either on to the next name length or into trailing bytes
  function automatic void close_file();
    file_idx   = file_idx + WORD_W'(1);
    files_left = files_left - WORD_W'(1);
    prs_phase  = (files_left == 0) ? PH_TRAIL : PH_NAMELEN;
  endfunction

  // tag one accepted byte and advance the mirrored parse state
  function automatic res_t deframe_byte(input logic [BYTE_W-1:0] b, input logic first,
                                        input logic last);
    res_t              r;
    logic [BYTE_W-1:0] want;
    if (first) restart_parse();
    r          = '0;
    r.byte_out = b;
    case (prs_phase)
      PH_MAGIC: begin
        // magic is compared msb first, one byte per beat
        want = magic_q[(3 - int'(hdr_pos)) * 8 +: 8];
        if (b != want) begin
          r.field_kind = KIND_REJECT;
          prs_phase    = PH_REJECT;
        end else begin
          r.field_kind = KIND_MAGIC;
          if (hdr_pos == 2'd3) begin
            r.field_last = 1'b1;
            hdr_pos      = '0;
            acc_q        = '0;
            prs_phase    = PH_COUNT;
          end else begin
            hdr_pos = hdr_pos + 2'd1;
          end
        end
      end
      PH_COUNT: begin
        r.field_kind = KIND_COUNT;
        acc_q        = {acc_q[23:0], b};
        if (hdr_pos == 2'd3) begin
          r.field_last = 1'b1;
          hdr_pos      = '0;
          files_left   = acc_q;
          acc_q        = '0;
          // a count of zero goes straight to trailing
          prs_phase    = (files_left == 0) ? PH_TRAIL : PH_NAMELEN;
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
      end
      PH_NAMELEN: begin
        r.field_kind = KIND_NAMELEN;
        r.file_num   = file_idx;
        acc_q        = {acc_q[23:0], b};
        if (hdr_pos >= 2'd1) begin
          r.field_last = 1'b1;
          hdr_pos      = '0;
          bytes_left   = {16'h0000, acc_q[15:0]};
          acc_q        = '0;
          // empty name skips to the size field
          prs_phase    = (bytes_left == 0) ? PH_SIZE : PH_NAME;
        end else begin
          hdr_pos = 2'd1;
        end
      end
      PH_NAME: begin
        r.field_kind = KIND_NAME;
        r.file_num   = file_idx;
        bytes_left   = bytes_left - WORD_W'(1);
        if (bytes_left == 0) begin
          r.field_last = 1'b1;
          hdr_pos      = '0;
          acc_q        = '0;
          prs_phase    = PH_SIZE;
        end
      end
      PH_SIZE: begin
        r.field_kind = KIND_SIZE;
        r.file_num   = file_idx;
        acc_q        = {acc_q[23:0], b};
        if (hdr_pos == 2'd3) begin
          r.field_last = 1'b1;
          hdr_pos      = '0;
          bytes_left   = acc_q;
          acc_q        = '0;
          // empty data closes the file at once
          if (bytes_left == 0) close_file();
          else prs_phase = PH_DATA;
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
      end
      PH_DATA: begin
        r.field_kind = KIND_DATA;
        r.file_num   = file_idx;
        bytes_left   = bytes_left - WORD_W'(1);
        if (bytes_left == 0) begin
          r.field_last = 1'b1;
          acc_q        = '0;
          close_file();
        end
      end
      PH_TRAIL: begin
        r.field_kind = KIND_TRAIL;
        r.file_num   = file_idx;
      end
      default: r.field_kind = KIND_REJECT;
    endcase
    r.all_files_done = (prs_phase == PH_TRAIL);
    // an archive that ends mid-parse is flagged, unless already rejected
    r.truncated      = last && prs_phase != PH_TRAIL && prs_phase != PH_REJECT;
    if (last) restart_parse();
    return r;
  endfunction

  function automatic logic src_gap();
    case (mode)
      MODE_SRC_GAPS: return $urandom_range(99) < 54;
      MODE_BOTH:     return $urandom_range(99) < 20;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic snk_stall();
    case (mode)
      MODE_SNK_STALLS: return $urandom_range(99) < 54;
      MODE_BOTH:       return $urandom_range(99) < 20;
      default:         return 1'b0;
    endcase
  endfunction

  task automatic add_beat(input logic [BYTE_W-1:0] data, input logic first,
                          input logic last, input logic pinned = 1'b0,
                          input field_kind_e kind = KIND_MAGIC,
                          input logic fld_last = 1'b0, input logic done = 1'b0,
                          input logic trunc = 1'b0);
    beat_t bt;
    bt.data                      = data;
    bt.first                     = first;
    bt.last                      = last;
    bt.pinned                    = pinned;
    bt.pinned_tag                = '0;
    bt.pinned_tag.field_kind     = kind;
    bt.pinned_tag.byte_out       = data;
    bt.pinned_tag.field_last     = fld_last;
    bt.pinned_tag.all_files_done = done;
    bt.pinned_tag.truncated      = trunc;
    beat_q.insert(beat_q.size(), bt);
  endtask

  // hand-written archive on the reset magic; tags pinned where obvious
  task automatic load_directed();
    add_beat(8'h50, 1'b1, 1'b0, 1'b1, KIND_MAGIC);
    add_beat(8'h4B, 1'b0, 1'b0, 1'b1, KIND_MAGIC);
    add_beat(8'h03, 1'b0, 1'b0, 1'b1, KIND_MAGIC);
    add_beat(8'h04, 1'b0, 1'b0, 1'b1, KIND_MAGIC, 1'b1);
    // two files: the first with empty name and empty data
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h02, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    // second file: one name byte, one data byte
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h01, 1'b0, 1'b0);
    add_beat(8'hFF, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0); add_beat(8'h01, 1'b0, 1'b0);
    add_beat(8'hAA, 1'b0, 1'b0);
    // trailing byte closes the archive
    add_beat(8'hFF, 1'b0, 1'b1);
    // start and end on one beat: a one-byte archive, cut short in the magic
    add_beat(8'h50, 1'b1, 1'b1, 1'b1, KIND_MAGIC, 1'b0, 1'b0, 1'b1);
    // bad first magic byte without start mark, then a rejected follow-on byte
    add_beat(8'h00, 1'b0, 1'b0, 1'b1, KIND_REJECT);
    add_beat(8'hFF, 1'b0, 1'b1, 1'b1, KIND_REJECT);
  endtask

  // one archive: mostly well formed with random content, some broken or noise
  task automatic gen_archive();
    logic [BYTE_W-1:0] raw[$];
    logic [WORD_W-1:0] count_field;
    int unsigned       pick;
    int unsigned       n_files;
    int unsigned       name_len;
    int unsigned       data_len;
    int unsigned       n;
    logic              open_end;
    pick     = $urandom_range(99);
    open_end = 1'b0;
    if (pick < 12) begin
      // raw noise with random start and end marks
      n = $urandom_range(12, 1);
      repeat (n) add_beat(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
      return;
    end
    for (int k = 0; k < 4; k++) raw.insert(raw.size(), magic_q[(3 - k) * 8 +: 8]);
    if (pick < 24) raw[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
    n_files     = $urandom_range(3);
    // now and then a huge count, left unfinished
    count_field = ($urandom_range(24) == 0) ? $urandom : n_files;
    for (int k = 0; k < 4; k++) raw.insert(raw.size(), count_field[(3 - k) * 8 +: 8]);
    for (int f = 0; f < n_files && !open_end; f++) begin
      name_len = ($urandom_range(29) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(4);
      raw.insert(raw.size(), 8'(name_len >> 8));
      raw.insert(raw.size(), 8'(name_len));
      if (name_len > 4) begin
        open_end = 1'b1;
      end else begin
        repeat (name_len) raw.insert(raw.size(), 8'($urandom));
        data_len = ($urandom_range(29) == 0) ? $urandom : $urandom_range(6);
        for (int k = 0; k < 4; k++) raw.insert(raw.size(), 8'(data_len >> ((3 - k) * 8)));
        if (data_len > 6) open_end = 1'b1;
        else repeat (data_len) raw.insert(raw.size(), 8'($urandom));
      end
    end
    if (!open_end) repeat ($urandom_range(3)) raw.insert(raw.size(), 8'($urandom));
    // cut some archives short
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(raw.size() - 1, 1);
      while (raw.size() > n) void'(raw.pop_back());
    end
    // start and end marks are mostly present, sometimes dropped
    for (int k = 0; k < raw.size(); k++)
      add_beat(raw[k], (k == 0) ? ($urandom_range(9) != 0) : 1'b0,
               (k == raw.size() - 1) ? ($urandom_range(9) != 0) : 1'b0);
  endtask

  // drive queued beats; expectation is taken at the accepting edge
  task automatic send_beats();
    beat_t bt;
    res_t  tag;
    while (beat_q.size() != 0) begin
      bt = beat_q.pop_front();
      if (src_gap()) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (src_gap());
      end
      in_if.valid         <= 1'b1;
      in_if.stream_byte   <= bt.data;
      in_if.archive_start <= bt.first;
      in_if.archive_end   <= bt.last;
      do @(posedge clk_i); while (!in_if.ready);
      tag = deframe_byte(bt.data, bt.first, bt.last);
      tag_q.insert(tag_q.size(), bt.pinned ? bt.pinned_tag : tag);
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tag_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write at the next edge, mirrored at the same edge
  task automatic write_magic(input logic [WORD_W-1:0] value);
    magic_we    <= 1'b1;
    magic_wdata <= value;
    @(posedge clk_i);
    magic_q = value;
    magic_we <= 1'b0;
  endtask

  task automatic check_tag();
    res_t want;
    if (tag_q.size() == 0) begin
      $error("unexpected output beat: kind %0d byte %0h", out_if.field_kind, out_if.byte_out);
      n_errors++;
      return;
    end
    want = tag_q.pop_front();
    if (out_if.field_kind !== want.field_kind) begin
      $error("field_kind: expected %0d, actual %0d", want.field_kind, out_if.field_kind);
      n_errors++;
    end
    if (out_if.byte_out !== want.byte_out) begin
      $error("byte_out: expected %0h, actual %0h", want.byte_out, out_if.byte_out);
      n_errors++;
    end
    if (out_if.file_num !== want.file_num) begin
      $error("file_num: expected %0d, actual %0d", want.file_num, out_if.file_num);
      n_errors++;
    end
    if (out_if.field_last !== want.field_last) begin
      $error("field_last: expected %0b, actual %0b", want.field_last, out_if.field_last);
      n_errors++;
    end
    if (out_if.all_files_done !== want.all_files_done) begin
      $error("all_files_done: expected %0b, actual %0b", want.all_files_done,
             out_if.all_files_done);
      n_errors++;
    end
    if (out_if.truncated !== want.truncated) begin
      $error("truncated: expected %0b, actual %0b", want.truncated, out_if.truncated);
      n_errors++;
    end
  endtask

  // receiver: check the beat taken at this edge, then pick ready for the next
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_tag();
    out_if.ready <= !snk_stall();
  end

  // watchdog: too long without any beat moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    magic_we            <= 1'b0;
    magic_wdata         <= '0;
    in_if.valid         <= 1'b0;
    in_if.stream_byte   <= '0;
    in_if.archive_start <= 1'b0;
    in_if.archive_end   <= 1'b0;
    restart_parse();
    magic_q = MAGIC_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int run = 0; run < RUNS; run++) begin
      mode = idle_mode_e'(run % 4);
      if (run == 0) begin
        // first run relies on the reset value of the magic
        load_directed();
      end else begin
        drain();
        case (run)
          1:       write_magic('0);
          2:       write_magic('1);
          4:       write_magic(MAGIC_RST);
          default: write_magic($urandom);
        endcase
      end
      while (beat_q.size() < BEATS_PER_RUN) gen_archive();
      send_beats();
    end

    drain();
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/asd_pkg.sv
rtl/core/asd_stream_if.sv
rtl/core/asd_parser.sv
rtl/core/asd_fifo.sv
rtl/core/asd_emit.sv
rtl/core/archive_stream_deframer_core.sv
tb/sv/tb_archive_stream_deframer_core.sv
